// ===== hdl/qetr_pkg.sv =====
// ----------------------------------------------------------------------------
// qetr_pkg: shared types and constants of the escape-time ray engine
// Working number format, saturation helper, register indexes and the
// result record passed from the iteration engine to the output stage.
// ----------------------------------------------------------------------------
package qetr_pkg;

  // Default configuration of the top level.
  localparam int COORD_BITS_DEF = 32;
  localparam int ITER_BITS_DEF  = 12;

  // Working format: signed Q10.38 in 48 bits.
  localparam int WORK_BITS = 48;
  localparam int WORK_FRAC = 38;
  localparam int HALF_BITS = WORK_BITS / 2;
  // Integer bits of a coordinate; the shift into the working format is
  // WORK_FRAC + COORD_INT_BITS - COORD_BITS.
  localparam int COORD_INT_BITS = 6;

  typedef logic signed [WORK_BITS-1:0] work_t;
  typedef logic signed [WORK_BITS:0]   wide_t;

  localparam work_t WORK_MAX = {1'b0, {(WORK_BITS-1){1'b1}}};
  localparam work_t WORK_MIN = {1'b1, {(WORK_BITS-1){1'b0}}};

  // Escape radius squared, 100.0 in the working format.
  localparam int    ESC_MAG   = 100;
  localparam wide_t ESC_LIMIT = (WORK_BITS+1)'(ESC_MAG) <<< WORK_FRAC;

  // Result code.
  localparam int CODE_BITS  = 15;
  localparam int DEC_OFFSET = 11;

  // Configuration registers.
  localparam int CFG_IDX_BITS   = 2;
  localparam int MAX_ITER_RESET = 500;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_START_RE,
    CFG_START_IM,
    CFG_MAX_ITER
  } cfg_idx_e;

  // Output stream payload, escaped flag in bit 0 and code above it.
  localparam int OUT_TDATA_BITS = ((1 + CODE_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic                 escaped;
  } res_t;

  // Clamp a value one bit wider than the working format into it.
  function automatic work_t sat_work(input wide_t v);
    work_t r;
    if (v[WORK_BITS] && !v[WORK_BITS-1]) begin
      r = WORK_MIN;
    end else if (!v[WORK_BITS] && v[WORK_BITS-1]) begin
      r = WORK_MAX;
    end else begin
      r = v[WORK_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/qetr_mul.sv =====
// ----------------------------------------------------------------------------
// qetr_mul: iterative saturating fixed-point multiplier
// Multiplies two working-format values on their magnitudes with one
// 24x24 multiplier over four partial products, truncates toward zero,
// applies the sign and saturates.
// ----------------------------------------------------------------------------
module qetr_mul
  import qetr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  work_t a_i,
  input  work_t b_i,
  output logic  done_o,
  output work_t p_o
);

  localparam int ACC_BITS = 2 * WORK_BITS;
  localparam int R_BITS   = ACC_BITS - WORK_FRAC;
  localparam logic [2:0] K_WB = 3'd4;

  logic [WORK_BITS-1:0] mag_a, mag_b;
  logic [WORK_BITS-1:0] ma_q, mb_q;
  logic                 neg_q;
  logic [ACC_BITS-1:0]  acc_q;
  logic [2:0]           k_q;
  logic                 busy_q;
  logic                 done_q;
  work_t                p_q;

  logic [HALF_BITS-1:0] x, y;
  logic [WORK_BITS-1:0] pp;
  logic [ACC_BITS-1:0]  pp_ext;
  logic [R_BITS-1:0]    r;
  logic                 pos_ovf, neg_ovf;
  work_t                res;

  assign mag_a = a_i[WORK_BITS-1] ? (~a_i + 1'b1) : a_i;
  assign mag_b = b_i[WORK_BITS-1] ? (~b_i + 1'b1) : b_i;

  // Partial products: low*low, high*low, low*high, high*high.
  always_comb begin
    case (k_q[1:0])
      2'd0: begin
        x = ma_q[HALF_BITS-1:0];
        y = mb_q[HALF_BITS-1:0];
      end
      2'd1: begin
        x = ma_q[WORK_BITS-1:HALF_BITS];
        y = mb_q[HALF_BITS-1:0];
      end
      2'd2: begin
        x = ma_q[HALF_BITS-1:0];
        y = mb_q[WORK_BITS-1:HALF_BITS];
      end
      default: begin
        x = ma_q[WORK_BITS-1:HALF_BITS];
        y = mb_q[WORK_BITS-1:HALF_BITS];
      end
    endcase
  end

  assign pp = x * y;

  always_comb begin
    case (k_q[1:0])
      2'd0:    pp_ext = {{WORK_BITS{1'b0}}, pp};
      2'd3:    pp_ext = {pp, {WORK_BITS{1'b0}}};
      default: pp_ext = {{HALF_BITS{1'b0}}, pp, {HALF_BITS{1'b0}}};
    endcase
  end

  // Truncated magnitude and its saturation.
  assign r       = acc_q[ACC_BITS-1:WORK_FRAC];
  assign pos_ovf = |r[R_BITS-1:WORK_BITS-1];
  assign neg_ovf = (|r[R_BITS-1:WORK_BITS]) ||
                   (r[WORK_BITS-1] && (|r[WORK_BITS-2:0]));

  always_comb begin
    if (neg_q) begin
      res = neg_ovf ? WORK_MIN : work_t'(~r[WORK_BITS-1:0] + 1'b1);
    end else begin
      res = pos_ovf ? WORK_MAX : work_t'(r[WORK_BITS-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ma_q   <= '0;
      mb_q   <= '0;
      neg_q  <= 1'b0;
      acc_q  <= '0;
      k_q    <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      p_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        ma_q   <= mag_a;
        mb_q   <= mag_b;
        neg_q  <= a_i[WORK_BITS-1] ^ b_i[WORK_BITS-1];
        acc_q  <= '0;
        k_q    <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (k_q == K_WB) begin
          p_q    <= res;
          done_q <= 1'b1;
          busy_q <= 1'b0;
        end else begin
          acc_q <= acc_q + pp_ext;
          k_q   <= k_q + 3'd1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("multiplier started while busy");

  a_k_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (k_q <= K_WB))
    else $error("partial product counter out of range");

  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (!busy_q && $past(busy_q)))
    else $error("product done without a preceding run");

endmodule

// ===== hdl/qetr_engine.sv =====
// ----------------------------------------------------------------------------
// qetr_engine: escape-time iteration sequencer
// Converts the point and start value into the working format, runs the
// shared multiplier three times per step and applies the update, the
// escape test and the step limit, then builds the result code.
// ----------------------------------------------------------------------------
module qetr_engine
  import qetr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ITER_BITS  = ITER_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [COORD_BITS-1:0] c_re_i,
  input  logic [COORD_BITS-1:0] c_im_i,
  input  logic [COORD_BITS-1:0] z_re_i,
  input  logic [COORD_BITS-1:0] z_im_i,
  input  logic [ITER_BITS-1:0]  limit_i,
  output logic                  idle_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output res_t                  res_o
);

  localparam int SHIFT = WORK_FRAC + COORD_INT_BITS - COORD_BITS;
  localparam int LSH   = (SHIFT > 0) ? SHIFT : 0;
  localparam int RSH   = (SHIFT < 0) ? -SHIFT : 0;
  localparam int SUM_BITS = (ITER_BITS + 2 > CODE_BITS) ? ITER_BITS + 2 : CODE_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_TEST,
    ST_UPD_A,
    ST_UPD_B,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PR_REIM,
    PR_RERE,
    PR_IMIM
  } prod_e;

  // Sign-extend, then shift into Q10.38; a right shift rounds toward
  // minus infinity.
  function automatic work_t to_work(input logic [COORD_BITS-1:0] v);
    work_t x;
    x = work_t'($signed(v));
    return (x <<< LSH) >>> RSH;
  endfunction

  state_e               state_q;
  prod_e                sel_q;
  logic                 start_q;
  work_t                re_q, im_q, cre_q, cim_q;
  work_t                pr_q, re2_q, im2_q;
  work_t                p2_q, d_q;
  logic [ITER_BITS-1:0] i_q, lim_q;
  res_t                 res_q;

  work_t                mul_a, mul_b, mul_p;
  logic                 mul_done;
  wide_t                sum_sq, diff_sq, dbl_p, sum_im, sum_re;
  logic                 below, in_limit;
  logic [SUM_BITS-1:0]  code_sum;

  always_comb begin
    unique case (sel_q)
      PR_REIM: begin
        mul_a = re_q;
        mul_b = im_q;
      end
      PR_RERE: begin
        mul_a = re_q;
        mul_b = re_q;
      end
      PR_IMIM: begin
        mul_a = im_q;
        mul_b = im_q;
      end
      default: begin
        mul_a = re_q;
        mul_b = im_q;
      end
    endcase
  end

  qetr_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  // The escape test sums the squares at full width without clamping.
  assign sum_sq   = wide_t'(re2_q) + wide_t'(im2_q);
  assign below    = sum_sq < ESC_LIMIT;
  assign in_limit = i_q < lim_q;

  assign diff_sq = wide_t'(re2_q) - wide_t'(im2_q);
  assign dbl_p   = {pr_q, 1'b0};
  assign sum_im  = wide_t'(p2_q) + wide_t'(cim_q);
  assign sum_re  = wide_t'(d_q) + wide_t'(cre_q);

  // Binary decomposition: odd offset when the last imaginary part is negative.
  assign code_sum = (SUM_BITS'(i_q) << 1) +
                    (im_q[WORK_BITS-1] ? SUM_BITS'(DEC_OFFSET) : SUM_BITS'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= PR_REIM;
      start_q <= 1'b0;
      re_q    <= '0;
      im_q    <= '0;
      cre_q   <= '0;
      cim_q   <= '0;
      pr_q    <= '0;
      re2_q   <= '0;
      im2_q   <= '0;
      p2_q    <= '0;
      d_q     <= '0;
      i_q     <= '0;
      lim_q   <= '0;
      res_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            cre_q   <= to_work(c_re_i);
            cim_q   <= to_work(c_im_i);
            re_q    <= to_work(z_re_i);
            im_q    <= to_work(z_im_i);
            lim_q   <= limit_i;
            i_q     <= '0;
            sel_q   <= PR_REIM;
            start_q <= 1'b1;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          start_q <= 1'b0;
          if (mul_done) begin
            unique case (sel_q)
              PR_REIM: begin
                pr_q    <= mul_p;
                sel_q   <= PR_RERE;
                start_q <= 1'b1;
              end
              PR_RERE: begin
                re2_q   <= mul_p;
                sel_q   <= PR_IMIM;
                start_q <= 1'b1;
              end
              default: begin
                im2_q   <= mul_p;
                state_q <= ST_TEST;
              end
            endcase
          end
        end
        ST_TEST: begin
          if (in_limit && below) begin
            state_q <= ST_UPD_A;
          end else begin
            res_q.escaped <= in_limit;
            res_q.code    <= in_limit ? code_sum[CODE_BITS-1:0] : {CODE_BITS{1'b1}};
            state_q       <= ST_DONE;
          end
        end
        ST_UPD_A: begin
          p2_q    <= sat_work(dbl_p);
          d_q     <= sat_work(diff_sq);
          state_q <= ST_UPD_B;
        end
        ST_UPD_B: begin
          im_q    <= sat_work(sum_im);
          re_q    <= sat_work(sum_re);
          i_q     <= i_q + 1'b1;
          sel_q   <= PR_REIM;
          start_q <= 1'b1;
          state_q <= ST_MUL;
        end
        ST_DONE: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign idle_o      = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  a_done_in_mul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_MUL))
    else $error("product returned outside the multiply phase");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (i_q <= lim_q))
    else $error("step count passed the limit");

  a_no_escape_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !res_q.escaped) |-> (res_q.code == {CODE_BITS{1'b1}}))
    else $error("non-escaping point without the no-escape code");

endmodule

// ===== hdl/quadratic_escape_time_rays.sv =====
// ----------------------------------------------------------------------------
// quadratic_escape_time_rays: escape-time engine with binary decomposition
// Stream in points c, stream out escape flag and ray code per point.
// ----------------------------------------------------------------------------
// Each point c transferred on the input stream is iterated as z = z*z + c,
// starting from the configured z0, in saturating Q10.38 arithmetic. Before
// every step the engine tests re*re + im*im < 100; it stops when the test
// fails or when max_iterations steps are done. An escape after i steps gives
// code 2*i, or 2*i+11 when the final imaginary part is negative; no escape
// gives code -1 with escaped low. All products come from one 24x24 bit
// multiplier, used four times per 48-bit product and for three products per
// step (re*im, re*re, im*im). The input is ready only while the engine is
// idle; a finished result waits in the output register, so the next point
// can be taken while the previous result is still unclaimed.
// Configuration registers are written through the plain write port and
// take effect for the next point transferred.
module quadratic_escape_time_rays
  import qetr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ITER_BITS  = ITER_BITS_DEF,
  localparam int IN_TDATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Point stream. tdata: c_re, c_im, zero padding.
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_TDATA_BITS-1:0] s_axis_tdata,
  // Result stream. tdata: escaped, code[14:0].
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
  // Configuration write port.
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [COORD_BITS-1:0]    cfg_wdata_i
);

  logic [COORD_BITS-1:0] start_re_q, start_im_q;
  logic [ITER_BITS-1:0]  max_iter_q;

  logic eng_idle;
  logic eng_start;
  logic res_valid;
  logic res_ready;
  res_t res;

  logic m_valid_q;
  res_t m_data_q;

  // Configuration registers; an index outside the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_re_q <= '0;
      start_im_q <= '0;
      max_iter_q <= ITER_BITS'(MAX_ITER_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_RE: start_re_q <= cfg_wdata_i;
        CFG_START_IM: start_im_q <= cfg_wdata_i;
        CFG_MAX_ITER: max_iter_q <= cfg_wdata_i[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The point stream is ready whenever the engine is idle.
  assign s_axis_tready = eng_idle;
  assign eng_start     = s_axis_tvalid && eng_idle;

  qetr_engine #(
    .COORD_BITS (COORD_BITS),
    .ITER_BITS  (ITER_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (eng_start),
    .c_re_i      (s_axis_tdata[COORD_BITS-1:0]),
    .c_im_i      (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .z_re_i      (start_re_q),
    .z_im_i      (start_im_q),
    .limit_i     (max_iter_q),
    .idle_o      (eng_idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: refilled when empty or when its transfer completes.
  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
      if (res_valid) begin
        m_data_q <= res;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_TDATA_BITS'(m_data_q);

endmodule

// ===== tb/sv/tb_quadratic_escape_time_rays.sv =====
// ----------------------------------------------------------------------------
// tb_quadratic_escape_time_rays: self-checking bench for the escape-time engine
// Streams parameter points through the engine under several start points and
// step limits, predicts each escape flag and ray code in the bench, and
// compares every result transfer against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_quadratic_escape_time_rays;
  import qetr_pkg::*;

  localparam int COORD_W  = COORD_BITS_DEF;
  localparam int ITER_W   = ITER_BITS_DEF;
  localparam int IN_BITS  = ((2 * COORD_W + 7) / 8) * 8;
  // Left shift that moves a Q6.26 coordinate into Q10.38.
  localparam int COORD_SHIFT = WORK_FRAC + COORD_INT_BITS - COORD_W;

  localparam longint SAT_HI    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SAT_LO    = -SAT_HI - 1;
  localparam longint ESCAPE_R2 = longint'(ESC_MAG) <<< WORK_FRAC;

  // The index field is two bits wide but only three registers exist; writes
  // to the spare index must leave the configuration untouched.
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE = 2'd3;

  localparam int HOLD_CYCLES  = 1500;
  localparam int PHASE_POINTS = 50;
  localparam int RAND_PHASES  = 12;

  // Handy Q6.26 values.
  localparam logic [COORD_W-1:0] FX_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] FX_NEG_MAX = 32'h8000_0000;
  localparam logic [COORD_W-1:0] FX_MINUS_2 = 32'hF800_0000;
  localparam logic [COORD_W-1:0] FX_MINUS_1 = 32'hFC00_0000;
  localparam logic [COORD_W-1:0] FX_ELEVEN  = 32'h2C00_0000;
  localparam logic [COORD_W-1:0] FX_0P26    = 32'h010A_3D71;
  localparam logic [COORD_W-1:0] FX_0P3     = 32'h0133_3333;
  localparam logic [COORD_W-1:0] FX_M0P55   = 32'hFDCC_CCCD;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [IN_BITS-1:0]        s_axis_tdata;   // c_re, c_im
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;   // escaped, code[14:0]
  logic                      cfg_we_i;
  logic [CFG_IDX_BITS-1:0]   cfg_idx_i;
  logic [COORD_W-1:0]        cfg_wdata_i;

  quadratic_escape_time_rays u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Keeps the bench's own copy of the three registers, predicts the ray code
  // of every accepted point and checks the result stream in order.
  class ray_code_tracker;
    logic [COORD_W-1:0] start_re;
    logic [COORD_W-1:0] start_im;
    logic [ITER_W-1:0]  max_iter;
    res_t               codes_due[$];
    int                 mismatches;
    int                 points;
    int                 escapes;
    int                 limit_hits;

    function new();
      start_re   = '0;
      start_im   = '0;
      max_iter   = ITER_W'(MAX_ITER_RESET);
      mismatches = 0;
      points     = 0;
      escapes    = 0;
      limit_hits = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [COORD_W-1:0] value);
      case (idx)
        CFG_START_RE: start_re = value;
        CFG_START_IM: start_im = value;
        CFG_MAX_ITER: max_iter = value[ITER_W-1:0];
        default: ;
      endcase
    endfunction

    function longint to_q10(logic [COORD_W-1:0] raw);
      return longint'($signed(raw)) <<< COORD_SHIFT;
    endfunction

    function longint clamp48(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
    endfunction

    // Exact product of the magnitudes, truncated toward zero, then signed
    // and clamped to the working range.
    function longint mul_q10(longint a, longint b);
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic [127:0] prod;
      bit           neg;
      neg  = (a < 0) != (b < 0);
      ma   = (a < 0) ? -a : a;
      mb   = (b < 0) ? -b : b;
      prod = ma * mb;
      prod = prod >> WORK_FRAC;
      if (neg) begin
        if (prod > 128'(SAT_HI) + 1) return SAT_LO;
        return -longint'(prod[63:0]);
      end
      if (prod > 128'(SAT_HI)) return SAT_HI;
      return longint'(prod[63:0]);
    endfunction

    function res_t escape_code(logic [COORD_W-1:0] c_re, logic [COORD_W-1:0] c_im);
      longint      cre;
      longint      cim;
      longint      re;
      longint      im;
      longint      re2;
      longint      im2;
      longint      nre;
      longint      nim;
      int unsigned steps;
      res_t        r;
      cre   = to_q10(c_re);
      cim   = to_q10(c_im);
      re    = to_q10(start_re);
      im    = to_q10(start_im);
      re2   = mul_q10(re, re);
      im2   = mul_q10(im, im);
      steps = 0;
      // The magnitude test comes before every step, on unclamped squares.
      while (steps < max_iter && re2 + im2 < ESCAPE_R2) begin
        nim   = clamp48(clamp48(mul_q10(re, im) * 2) + cim);
        nre   = clamp48(clamp48(re2 - im2) + cre);
        re    = nre;
        im    = nim;
        re2   = mul_q10(re, re);
        im2   = mul_q10(im, im);
        steps = steps + 1;
      end
      if (steps < max_iter) begin
        r.escaped = 1'b1;
        r.code    = CODE_BITS'(2 * steps + ((im < 0) ? DEC_OFFSET : 0));
      end else begin
        r.escaped = 1'b0;
        r.code    = '1;
      end
      return r;
    endfunction

    function void note_point(logic [COORD_W-1:0] c_re, logic [COORD_W-1:0] c_im);
      res_t r;
      r = escape_code(c_re, c_im);
      codes_due.push_back(r);
      points = points + 1;
      if (r.escaped) escapes = escapes + 1;
      else limit_hits = limit_hits + 1;
    endfunction

    function void check_result(logic [OUT_TDATA_BITS-1:0] beat);
      res_t got;
      res_t want;
      got = res_t'(beat[$bits(res_t)-1:0]);
      if (codes_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual escaped %0d code %0d",
                 $time, got.escaped, $signed(got.code));
        mismatches = mismatches + 1;
        return;
      end
      want = codes_due.pop_front();
      if (got.escaped !== want.escaped || got.code !== want.code) begin
        $display("%0t: result mismatch, expected escaped %0d code %0d, actual escaped %0d code %0d",
                 $time, want.escaped, $signed(want.code), got.escaped, $signed(got.code));
        mismatches = mismatches + 1;
      end
    endfunction
  endclass

  ray_code_tracker tracker;

  bit idle_on;        // random gaps on the point side and stalls on the result side
  bit hold_request;   // asks the result side for one long hold-off
  int reg_writes;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Both streams are observed at the clock edge; the bench drives its side
  // with nonblocking assignments, so the sampled values are the pre-edge ones.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      tracker.note_point(s_axis_tdata[COORD_W-1:0], s_axis_tdata[2*COORD_W-1:COORD_W]);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_result(m_axis_tdata);
    end
  end

  // Result side. Stalls come in short random bursts while idling is on; a
  // hold request drops tready for a long counted stretch so that a finished
  // result sits in the output register, the next point completes behind it,
  // and the engine stops taking points.
  initial begin
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Offers one point and returns at the edge where the transfer happens.
  // tvalid stays high into the next point unless a gap is drawn.
  task automatic send_point(input logic [COORD_W-1:0] c_re, input logic [COORD_W-1:0] c_im);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_BITS'({c_im, c_re});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Registers are only written with nothing in flight.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [COORD_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.set_reg(idx, value);
    reg_writes = reg_writes + 1;
    @(posedge clk_i);
  endtask

  // Lowers tvalid and waits until every predicted result has been checked.
  // Every point yields exactly one result, so an empty queue means the engine
  // is idle, and the task ends with an extra wait.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (tracker.codes_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Most points land near the set so the orbit runs for a while; some reach
  // further out and some use every bit of the field.
  function automatic logic [COORD_W-1:0] pick_coord();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return COORD_W'(int'($urandom_range(0, 335544320)) - 167772160);
    if (sel < 9) return COORD_W'(int'($urandom_range(0, 32'h7FFF_FFFF)) - 32'h4000_0000);
    return COORD_W'($urandom());
  endfunction

  function automatic logic [COORD_W-1:0] pick_start();
    if ($urandom_range(0, 9) < 6) begin
      return COORD_W'(int'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000);
    end
    return pick_coord();
  endfunction

  // One random phase: a fresh setting, then a run of random points. A
  // squeezed phase keeps the step limit short and asks for the long hold-off.
  task automatic run_random_phase(input bit squeeze);
    logic [ITER_W-1:0] limit;
    limit = (squeeze) ? ITER_W'(8) : ITER_W'($urandom_range(0, 32));
    write_reg(CFG_START_RE, pick_start());
    write_reg(CFG_START_IM, pick_start());
    write_reg(CFG_MAX_ITER, COORD_W'(limit));
    if (squeeze) hold_request = 1'b1;
    repeat (PHASE_POINTS) send_point(pick_coord(), pick_coord());
    wait_results_drained();
  endtask

  initial begin
    tracker      = new();
    idle_on      = 1'b1;
    hold_request = 1'b0;
    reg_writes   = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_wdata_i   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting: z0 at the origin, 500 steps. The origin and -2 stay
    // bounded, the corners escape after one step with either sign of the
    // imaginary part, and 0.26 escapes after a long slow orbit.
    send_point('0, '0);
    send_point(FX_POS_MAX, FX_POS_MAX);
    send_point(FX_NEG_MAX, FX_NEG_MAX);
    send_point(FX_NEG_MAX, FX_POS_MAX);
    send_point(FX_MINUS_2, '0);
    send_point('0, FX_MINUS_1);
    send_point(FX_0P26, '0);
    send_point(FX_0P3, FX_M0P55);
    wait_results_drained();

    // A write to the spare index changes nothing; then z0 at the extremes
    // already fails the magnitude test, so the code is 0 or 11.
    write_reg(CFG_IDX_SPARE, 32'h1234_5678);
    write_reg(CFG_START_RE, FX_POS_MAX);
    write_reg(CFG_START_IM, FX_NEG_MAX);
    send_point('0, '0);
    send_point(FX_POS_MAX, FX_NEG_MAX);
    wait_results_drained();
    write_reg(CFG_START_RE, FX_NEG_MAX);
    write_reg(CFG_START_IM, FX_POS_MAX);
    send_point(32'h1234_5678, 32'h9ABC_DEF0);
    wait_results_drained();

    // Zero limit: no step at all, even though z0 lies outside the radius.
    write_reg(CFG_MAX_ITER, '0);
    send_point('0, '0);
    send_point(FX_NEG_MAX, FX_POS_MAX);
    wait_results_drained();

    // c = 11 escapes on the test after the first step: a limit of one step
    // hides that escape, a limit of two reports it.
    write_reg(CFG_START_RE, '0);
    write_reg(CFG_START_IM, '0);
    write_reg(CFG_MAX_ITER, COORD_W'(1));
    send_point(FX_ELEVEN, '0);
    wait_results_drained();
    write_reg(CFG_MAX_ITER, COORD_W'(2));
    send_point(FX_ELEVEN, '0);
    wait_results_drained();

    // Largest limit; the origin runs all 4095 steps.
    write_reg(CFG_MAX_ITER, '1);
    send_point('0, '0);
    send_point(FX_POS_MAX, '0);
    send_point(FX_0P26, FX_M0P55);
    wait_results_drained();

    // Random phases; the fifth one fills the engine behind a held result
    // stream, and the last one runs with no idling on either side.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == RAND_PHASES - 1) idle_on = 1'b0;
      run_random_phase(ph == 4);
    end

    repeat (200) @(posedge clk_i);
    $display("Checked %0d points (%0d escaped, %0d ran out of steps) over %0d register writes,",
             tracker.points, tracker.escapes, tracker.limit_hits, reg_writes);
    $display("with step limits from 0 to 4095, start points at the extremes and a long stall.");
    if (tracker.mismatches == 0 && tracker.codes_due.size() == 0) begin
      $display("tb_quadratic_escape_time_rays OK");
    end else begin
      $display("tb_quadratic_escape_time_rays NOT OK");
    end
    $finish;
  end

  // Safety net, several times the slowest legal run.
  initial begin
    #40_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, tracker.codes_due.size());
    $display("tb_quadratic_escape_time_rays NOT OK");
    $finish;
  end

endmodule
